// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, codes and helper functions of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int NUM_PAGES_DEF  = 32768;
   localparam int NUM_ORDERS_DEF = 11;

   // request types
   localparam logic [1:0] REQ_INIT  = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ORDER = 2'd1;
   localparam logic [1:0] ST_NOBLK = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [4:0] {
      S_SWEEP,
      S_IDLE,
      S_DECODE,
      S_INIT_CLR,
      S_INIT_CARVE,
      S_INIT_LINK,
      S_AL_SEARCH,
      S_AL_RD,
      S_AL_LD,
      S_UL_W1,
      S_UL_W2,
      S_AL_SPLIT,
      S_AL_SPLINK,
      S_FR_MARK,
      S_FR_CHK,
      S_FR_TEST,
      S_FR_HI,
      S_FR_ORD,
      S_PH1,
      S_PH2
   } bpa_state_type;

   // per-field write enables of the page memory
   typedef struct packed {
      logic nxt;
      logic prv;
      logic ord;
      logic flg;
   } bpa_wen_type;

   // smallest order whose block holds n pages
   function automatic logic [4:0] round_order(input logic [15:0] n);
      logic [15:0] m;
      logic [4:0]  r;
      m = n - 16'd1;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (m[i]) r = 5'(i + 1);
      end
      if (n <= 16'd1) r = '0;
      return r;
   endfunction

   // index of the highest set bit
   function automatic logic [3:0] floor_log2(input logic [15:0] n);
      logic [3:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (n[i]) r = 4'(i);
      end
      return r;
   endfunction

endpackage

// ===== src/bpa_page_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_page_ram
// per-page store of next link, prev link, order and head flag; one write
// port with field enables, one read port with registered data
// ----------------------------------------------------------------------------
module bpa_page_ram #(
   parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
   input  logic                                  clock,
   input  bpa_pkg::bpa_wen_type                  wen,
   input  logic [$clog2(NUM_PAGES)-1:0]          waddr,
   input  logic [$clog2(NUM_PAGES):0]            wnext,
   input  logic [$clog2(NUM_PAGES):0]            wprev,
   input  logic [$clog2(NUM_ORDERS+1)-1:0]       worder,
   input  logic                                  wflag,
   input  logic [$clog2(NUM_PAGES)-1:0]          raddr,
   output logic [$clog2(NUM_PAGES):0]            rnext,
   output logic [$clog2(NUM_PAGES):0]            rprev,
   output logic [$clog2(NUM_ORDERS+1)-1:0]       rorder,
   output logic                                  rflag
);
   import bpa_pkg::*;

   localparam int LW = $clog2(NUM_PAGES) + 1;
   localparam int OW = $clog2(NUM_ORDERS + 1);
   localparam int WW = 2 * LW + OW + 1;

   logic [WW-1:0] mem [NUM_PAGES];
   logic [WW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wen.nxt) mem[waddr][WW-1 -: LW] <= wnext;
      if (wen.prv) mem[waddr][WW-LW-1 -: LW] <= wprev;
      if (wen.ord) mem[waddr][OW:1] <= worder;
      if (wen.flg) mem[waddr][0] <= wflag;
      rd_ff <= mem[raddr];
   end

   assign rnext  = rd_ff[WW-1 -: LW];
   assign rprev  = rd_ff[WW-LW-1 -: LW];
   assign rorder = rd_ff[OW:1];
   assign rflag  = rd_ff[0];

endmodule

// ===== src/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// request sequencer: list heads and tails, free total, and the read-modify-
// write steps of init, allocate, free and merge against the page memory
// ----------------------------------------------------------------------------
module bpa_ctrl #(
   parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_type,
   input  logic [14:0]                           req_page_index,
   input  logic [15:0]                           req_page_count,
   input  logic [15:0]                           page_limit,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [14:0]                           rsp_block_index,
   output logic [15:0]                           rsp_free_total,
   output bpa_pkg::bpa_wen_type                  ram_wen,
   output logic [$clog2(NUM_PAGES)-1:0]          ram_waddr,
   output logic [$clog2(NUM_PAGES):0]            ram_wnext,
   output logic [$clog2(NUM_PAGES):0]            ram_wprev,
   output logic [$clog2(NUM_ORDERS+1)-1:0]       ram_worder,
   output logic                                  ram_wflag,
   output logic [$clog2(NUM_PAGES)-1:0]          ram_raddr,
   input  logic [$clog2(NUM_PAGES):0]            ram_rnext,
   input  logic [$clog2(NUM_PAGES):0]            ram_rprev,
   input  logic [$clog2(NUM_ORDERS+1)-1:0]       ram_rorder,
   input  logic                                  ram_rflag
);
   import bpa_pkg::*;

   localparam int AW = $clog2(NUM_PAGES);
   localparam int LW = AW + 1;
   localparam int OW = $clog2(NUM_ORDERS + 1);
   localparam int KW = $clog2(NUM_ORDERS);
   localparam int MW = (AW > NUM_ORDERS) ? AW : NUM_ORDERS;
   localparam int CW = ((MW > 16) ? MW : 16) + 1;
   localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);
   localparam logic [CW-1:0] PAGES_C = CW'(NUM_PAGES);

   bpa_state_type state_ff, state_in;
   logic [OW-1:0] k_ff, k_in, want_ff, want_in;
   logic [AW-1:0] pp_ff, pp_in, bb_ff, bb_in, ptr_ff, ptr_in, sweep_ff, sweep_in;
   logic [15:0]   rem_ff, rem_in, cnt_ff, cnt_in, total_ff, total_in;
   logic [LW-1:0] pr_ff, pr_in, nx_ff, nx_in, h_ff, h_in;
   logic [1:0]    op_ff, op_in;
   logic [14:0]   idx_ff, idx_in;
   logic [LW-1:0] head_ff [NUM_ORDERS];
   logic [LW-1:0] head_in [NUM_ORDERS];
   logic [LW-1:0] tail_ff [NUM_ORDERS];
   logic [LW-1:0] tail_in [NUM_ORDERS];
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [14:0]   rsp_blk_ff, rsp_blk_in;

   logic          fin;
   logic [1:0]    fin_st;
   logic [14:0]   fin_blk;

   logic [CW-1:0] lim, pow_k, pow_kd, pow_kc, pow_w, bud, bsplit, hi_pg;
   logic [15:0]   tot_k, tot_kd, tot_kc;
   logic [KW-1:0] kx, kdx, kcx;
   logic [OW-1:0] kd, kc, wk;
   logic [4:0]    w5;
   logic [3:0]    fl;

   always_comb begin
      lim    = (CW'(page_limit) < PAGES_C) ? CW'(page_limit) : PAGES_C;
      kx     = k_ff[KW-1:0];
      kd     = k_ff - OW'(1);
      kdx    = kd[KW-1:0];
      fl     = floor_log2(rem_ff);
      kc     = ({1'b0, fl} < 5'(NUM_ORDERS - 1)) ? OW'(fl) : OW'(NUM_ORDERS - 1);
      kcx    = kc[KW-1:0];
      w5     = round_order(cnt_ff);
      wk     = OW'(w5);
      pow_k  = CW'(1) << k_ff;
      pow_kd = CW'(1) << kd;
      pow_kc = CW'(1) << kc;
      pow_w  = CW'(1) << wk;
      tot_k  = 16'(pow_k);
      tot_kd = 16'(pow_kd);
      tot_kc = 16'(pow_kc);
      bud    = CW'(pp_ff) ^ pow_k;
      bsplit = CW'(pp_ff) + pow_kd;
      hi_pg  = (bb_ff > pp_ff) ? CW'(bb_ff) : CW'(pp_ff);
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      want_in = want_ff;
      pp_in = pp_ff;
      bb_in = bb_ff;
      ptr_in = ptr_ff;
      sweep_in = sweep_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      total_in = total_ff;
      pr_in = pr_ff;
      nx_in = nx_ff;
      h_in = h_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_blk_in = rsp_blk_ff;
      fin = 1'b0;
      fin_st = ST_OK;
      fin_blk = '0;
      ram_wen = '0;
      ram_waddr = pp_ff;
      ram_wnext = NIL;
      ram_wprev = NIL;
      ram_worder = '0;
      ram_wflag = 1'b0;
      ram_raddr = pp_ff;

      case (state_ff)
         S_SWEEP: begin
            ram_wen = '1;
            ram_waddr = sweep_ff;
            ram_wnext = '0;
            ram_wprev = '0;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(NUM_PAGES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_type;
               idx_in = req_page_index;
               cnt_in = req_page_count;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               REQ_INIT: begin
                  if (CW'(idx_ff) + CW'(cnt_ff) > lim) begin
                     fin = 1'b1;
                     fin_st = ST_RANGE;
                  end else if (cnt_ff == 16'd0) begin
                     fin = 1'b1;
                  end else begin
                     ptr_in = AW'(idx_ff);
                     rem_in = cnt_ff;
                     state_in = S_INIT_CLR;
                  end
               end
               REQ_ALLOC: begin
                  if (w5 >= 5'(NUM_ORDERS)) begin
                     fin = 1'b1;
                     fin_st = ST_ORDER;
                  end else begin
                     want_in = wk;
                     k_in = wk;
                     state_in = S_AL_SEARCH;
                  end
               end
               REQ_FREE: begin
                  if (w5 >= 5'(NUM_ORDERS)) begin
                     fin = 1'b1;
                     fin_st = ST_ORDER;
                  end else if (CW'(idx_ff) + pow_w > lim) begin
                     fin = 1'b1;
                     fin_st = ST_RANGE;
                  end else begin
                     pp_in = AW'(idx_ff);
                     k_in = wk;
                     state_in = S_FR_MARK;
                  end
               end
               default: fin = 1'b1;
            endcase
         end
         S_INIT_CLR: begin
            ram_wen.ord = 1'b1;
            ram_wen.flg = 1'b1;
            ram_waddr = ptr_ff;
            ptr_in = ptr_ff + AW'(1);
            rem_in = rem_ff - 16'd1;
            if (rem_ff == 16'd1) begin
               ptr_in = AW'(idx_ff);
               rem_in = cnt_ff;
               state_in = S_INIT_CARVE;
            end
         end
         S_INIT_CARVE: begin
            ram_wen = '1;
            ram_waddr = ptr_ff;
            ram_wnext = NIL;
            ram_wprev = tail_ff[kcx];
            ram_worder = kc;
            ram_wflag = 1'b1;
            h_in = tail_ff[kcx];
            pp_in = ptr_ff;
            if (tail_ff[kcx] >= NIL) head_in[kcx] = LW'(ptr_ff);
            tail_in[kcx] = LW'(ptr_ff);
            total_in = total_ff + tot_kc;
            ptr_in = ptr_ff + AW'(pow_kc);
            rem_in = rem_ff - tot_kc;
            if (tail_ff[kcx] < NIL) state_in = S_INIT_LINK;
            else if (rem_ff == tot_kc) fin = 1'b1;
         end
         S_INIT_LINK: begin
            ram_wen.nxt = 1'b1;
            ram_waddr = h_ff[AW-1:0];
            ram_wnext = LW'(pp_ff);
            if (rem_ff == 16'd0) fin = 1'b1;
            else state_in = S_INIT_CARVE;
         end
         S_AL_SEARCH: begin
            if (k_ff == OW'(NUM_ORDERS)) begin
               fin = 1'b1;
               fin_st = ST_NOBLK;
            end else if (head_ff[kx] < NIL) begin
               pp_in = head_ff[kx][AW-1:0];
               state_in = S_AL_RD;
            end else begin
               k_in = k_ff + OW'(1);
            end
         end
         S_AL_RD: begin
            ram_raddr = pp_ff;
            state_in = S_AL_LD;
         end
         S_AL_LD: begin
            pr_in = ram_rprev;
            nx_in = ram_rnext;
            state_in = S_UL_W1;
         end
         S_UL_W1: begin
            if (pr_ff < NIL) begin
               ram_wen.nxt = 1'b1;
               ram_waddr = pr_ff[AW-1:0];
               ram_wnext = nx_ff;
            end else begin
               head_in[kx] = nx_ff;
            end
            state_in = S_UL_W2;
         end
         S_UL_W2: begin
            if (nx_ff < NIL) begin
               ram_wen.prv = 1'b1;
               ram_waddr = nx_ff[AW-1:0];
               ram_wprev = pr_ff;
            end else begin
               tail_in[kx] = pr_ff;
            end
            total_in = total_ff - tot_k;
            state_in = (op_ff == REQ_ALLOC) ? S_AL_SPLIT : S_FR_HI;
         end
         S_AL_SPLIT: begin
            if (k_ff > want_ff) begin
               k_in = kd;
               if (bsplit < PAGES_C) begin
                  ram_wen = '1;
                  ram_waddr = AW'(bsplit);
                  ram_wnext = head_ff[kdx];
                  ram_wprev = NIL;
                  ram_worder = kd;
                  ram_wflag = 1'b1;
                  h_in = head_ff[kdx];
                  bb_in = AW'(bsplit);
                  head_in[kdx] = LW'(bsplit);
                  if (head_ff[kdx] >= NIL) tail_in[kdx] = LW'(bsplit);
                  total_in = total_ff + tot_kd;
                  if (head_ff[kdx] < NIL) state_in = S_AL_SPLINK;
               end
            end else begin
               ram_wen.ord = 1'b1;
               ram_wen.flg = 1'b1;
               ram_worder = want_ff;
               fin = 1'b1;
               fin_blk = 15'(CW'(pp_ff));
            end
         end
         S_AL_SPLINK: begin
            ram_wen.prv = 1'b1;
            ram_waddr = h_ff[AW-1:0];
            ram_wprev = LW'(bb_ff);
            state_in = S_AL_SPLIT;
         end
         S_FR_MARK: begin
            ram_wen.ord = 1'b1;
            ram_wen.flg = 1'b1;
            ram_worder = k_ff;
            ram_wflag = 1'b1;
            state_in = S_FR_CHK;
         end
         S_FR_CHK: begin
            if (({1'b0, k_ff} + (OW+1)'(1) < (OW+1)'(NUM_ORDERS)) && (bud < lim)) begin
               ram_raddr = AW'(bud);
               bb_in = AW'(bud);
               state_in = S_FR_TEST;
            end else begin
               state_in = S_PH1;
            end
         end
         S_FR_TEST: begin
            if (ram_rflag && (ram_rorder == k_ff)) begin
               pr_in = ram_rprev;
               nx_in = ram_rnext;
               state_in = S_UL_W1;
            end else begin
               state_in = S_PH1;
            end
         end
         S_FR_HI: begin
            ram_wen.flg = 1'b1;
            ram_waddr = AW'(hi_pg);
            if (bb_ff < pp_ff) pp_in = bb_ff;
            k_in = k_ff + OW'(1);
            state_in = S_FR_ORD;
         end
         S_FR_ORD: begin
            ram_wen.ord = 1'b1;
            ram_worder = k_ff;
            state_in = S_FR_CHK;
         end
         S_PH1: begin
            ram_wen.nxt = 1'b1;
            ram_wen.prv = 1'b1;
            ram_wnext = head_ff[kx];
            ram_wprev = NIL;
            h_in = head_ff[kx];
            head_in[kx] = LW'(pp_ff);
            if (head_ff[kx] >= NIL) tail_in[kx] = LW'(pp_ff);
            total_in = total_ff + tot_k;
            if (head_ff[kx] < NIL) state_in = S_PH2;
            else fin = 1'b1;
         end
         S_PH2: begin
            ram_wen.prv = 1'b1;
            ram_waddr = h_ff[AW-1:0];
            ram_wprev = LW'(pp_ff);
            fin = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = fin_st;
         rsp_blk_in = fin_blk;
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      want_ff <= want_in;
      pp_ff <= pp_in;
      bb_ff <= bb_in;
      ptr_ff <= ptr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      pr_ff <= pr_in;
      nx_ff <= nx_in;
      h_ff <= h_in;
      op_ff <= op_in;
      idx_ff <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_blk_ff <= rsp_blk_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_blk_ff;
   assign rsp_free_total  = total_ff;

endmodule

// ===== src/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// buddy page allocator with one free list per order, state in a page memory
// throughput: one request at a time, busy until its result strobe
// reset: clears lists and total, then sweeps every page of the page memory
//   with busy high; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
   parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [14:0] req_page_index,
   input  logic [15:0] req_page_count,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [14:0] rsp_block_index,
   output logic [15:0] rsp_free_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import bpa_pkg::*;

   localparam int AW = $clog2(NUM_PAGES);
   localparam int LW = AW + 1;
   localparam int OW = $clog2(NUM_ORDERS + 1);

   logic [15:0]  limit_ff;
   bpa_wen_type  wen;
   logic [AW-1:0] waddr, raddr;
   logic [LW-1:0] wnext, wprev, rnext, rprev;
   logic [OW-1:0] worder, rorder;
   logic          wflag, rflag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'h8000;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   bpa_ctrl #(
      .NUM_PAGES  (NUM_PAGES),
      .NUM_ORDERS (NUM_ORDERS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_page_index  (req_page_index),
      .req_page_count  (req_page_count),
      .page_limit      (limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_block_index (rsp_block_index),
      .rsp_free_total  (rsp_free_total),
      .ram_wen         (wen),
      .ram_waddr       (waddr),
      .ram_wnext       (wnext),
      .ram_wprev       (wprev),
      .ram_worder      (worder),
      .ram_wflag       (wflag),
      .ram_raddr       (raddr),
      .ram_rnext       (rnext),
      .ram_rprev       (rprev),
      .ram_rorder      (rorder),
      .ram_rflag       (rflag)
   );

   bpa_page_ram #(
      .NUM_PAGES  (NUM_PAGES),
      .NUM_ORDERS (NUM_ORDERS)
   ) u_ram (
      .clock  (clock),
      .wen    (wen),
      .waddr  (waddr),
      .wnext  (wnext),
      .wprev  (wprev),
      .worder (worder),
      .wflag  (wflag),
      .raddr  (raddr),
      .rnext  (rnext),
      .rprev  (rprev),
      .rorder (rorder),
      .rflag  (rflag)
   );

   // accepted beat keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // result only once the request is finished
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // failed requests carry no block
   a_fail_blk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_block_index == 15'd0)
      else $error("block index on failed request");

endmodule
